### hw/rtl/rotenc_pkg.sv
// ----------------------------------------------------------------------------
// rotenc_pkg
// Shared types, constants and the quadrature transition table for the
// rotary encoder and push switch decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rotenc_pkg;

  localparam int TIME_WIDTH_DEF = 32;
  localparam int NOW_W          = 32;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_INDEX_W    = 2;
  localparam int DETENT_W       = 4;
  localparam int ACC_W          = 5;

  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST   = 16'd20;
  localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST = 16'd3000;
  localparam logic [DETENT_W-1:0]   DETENT_RST     = 4'd4;
  localparam logic [DETENT_W-1:0]   DETENT_MIN     = 4'd1;
  localparam logic [DETENT_W-1:0]   DETENT_MAX     = 4'd8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DEBOUNCE   = 2'd0,
    CFG_LONG_PRESS = 2'd1,
    CFG_DETENT     = 2'd2
  } cfg_index_t;

  typedef enum logic [1:0] {
    SW_NONE     = 2'd0,
    SW_PRESSED  = 2'd1,
    SW_RELEASED = 2'd2,
    SW_LONG     = 2'd3
  } sw_event_t;

  typedef logic signed [1:0] step_t;

  typedef struct packed {
    sw_event_t ev;
    logic      long_seen;
  } sw_result_t;

  localparam step_t QUAD_TABLE [16] = '{
    2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
    -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
  };

endpackage

`default_nettype wire

### hw/rtl/rotenc_if.sv
// ----------------------------------------------------------------------------
// rotenc_in_if / rotenc_out_if
// Valid/ready channels for pin samples and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rotenc_in_if;
  logic        valid;
  logic        ready;
  logic        line_a;
  logic        line_b;
  logic        switch_pressed;
  logic [31:0] now_ms;

  modport source (output valid, line_a, line_b, switch_pressed, now_ms, input ready);
  modport sink   (input valid, line_a, line_b, switch_pressed, now_ms, output ready);
endinterface

interface rotenc_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] rotation_step;
  logic [1:0]        switch_event;
  logic              long_press_seen;

  modport source (output valid, rotation_step, switch_event, long_press_seen, input ready);
  modport sink   (input valid, rotation_step, switch_event, long_press_seen, output ready);
endinterface

`default_nettype wire

### hw/rtl/rotary_encoder_with_button_core.sv
// ----------------------------------------------------------------------------
// rotary_encoder_with_button_core
// Output: the result of a transferred sample is valid in the output register in the
// following cycle. Throughput: one sample per cycle while the output is not stalled;
// the output register is reloaded in the cycle its result is taken.
// Reset: synchronous active-low rst_n restores register defaults and idle state.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_with_button_core #(
  parameter int TIME_WIDTH = rotenc_pkg::TIME_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  rotenc_in_if.sink                          in_chan,
  rotenc_out_if.source                       out_chan,
  input  wire                                cfg_we,
  input  wire  [rotenc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire  [rotenc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rotenc_pkg::*;

  logic [CFG_DATA_W-1:0] debounce_r;
  logic [CFG_DATA_W-1:0] long_press_r;
  logic [DETENT_W-1:0]   detent_r;

  logic       accept;
  logic       out_valid_r;
  step_t      step_r;
  sw_result_t sw_r;
  step_t      step;
  sw_result_t sw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
      detent_r     <= DETENT_RST;
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        CFG_DETENT:     detent_r     <= cfg_wdata[DETENT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;

  rotenc_quad u_quad (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (accept),
    .ab     ({in_chan.line_a, in_chan.line_b}),
    .detent (detent_r),
    .step   (step)
  );

  rotenc_switch #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_switch (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (accept),
    .raw          (in_chan.switch_pressed),
    .now          (in_chan.now_ms[TIME_WIDTH-1:0]),
    .debounce_len (debounce_r),
    .hold_len     (long_press_r),
    .result       (sw)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      out_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      step_r <= step;
      sw_r   <= sw;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.rotation_step   = step_r;
  assign out_chan.switch_event    = sw_r.ev;
  assign out_chan.long_press_seen = sw_r.long_seen;

endmodule

`default_nettype wire

### hw/rtl/rotenc_quad.sv
// ----------------------------------------------------------------------------
// rotenc_quad
// Quadrature transition decoder with a detent accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module rotenc_quad (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  wire  [1:0]                   ab,
  input  wire  [rotenc_pkg::DETENT_W-1:0] detent,
  output rotenc_pkg::step_t            step
);
  import rotenc_pkg::*;

  logic [1:0]              prev_ab_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] sum;
  logic signed [ACC_W-1:0] lim;
  logic [DETENT_W-1:0]     lim_u;

  always_comb begin
    if (detent < DETENT_MIN) begin
      lim_u = DETENT_MIN;
    end else if (detent > DETENT_MAX) begin
      lim_u = DETENT_MAX;
    end else begin
      lim_u = detent;
    end
    lim = $signed({1'b0, lim_u});
    sum = acc_r + ACC_W'(QUAD_TABLE[{prev_ab_r, ab}]);
    if (sum >= lim) begin
      acc_nxt = '0;
      step    = 2'sd1;
    end else if (sum <= -lim) begin
      acc_nxt = '0;
      step    = -2'sd1;
    end else begin
      acc_nxt = sum;
      step    = 2'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_ab_r <= 2'b11;
      acc_r     <= '0;
    end else if (en) begin
      prev_ab_r <= ab;
      acc_r     <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/rotenc_switch.sv
// ----------------------------------------------------------------------------
// rotenc_switch
// Push switch debouncer with press, release and long press detection.
// ----------------------------------------------------------------------------
`default_nettype none

module rotenc_switch #(
  parameter int TIME_WIDTH = rotenc_pkg::TIME_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              en,
  input  wire                              raw,
  input  wire  [TIME_WIDTH-1:0]            now,
  input  wire  [rotenc_pkg::CFG_DATA_W-1:0] debounce_len,
  input  wire  [rotenc_pkg::CFG_DATA_W-1:0] hold_len,
  output rotenc_pkg::sw_result_t           result
);
  import rotenc_pkg::*;

  logic                  raw_r;
  logic                  stable_r, stable_nxt;
  logic                  lpd_r, lpd_nxt;
  logic [TIME_WIDTH-1:0] change_r, change_nxt;
  logic [TIME_WIDTH-1:0] press_r, press_nxt;
  logic [TIME_WIDTH-1:0] since_change;
  logic [TIME_WIDTH-1:0] since_press;
  sw_event_t             ev;

  always_comb begin
    change_nxt   = (raw != raw_r) ? now : change_r;
    since_change = now - change_nxt;
    since_press  = now - press_r;
    stable_nxt   = stable_r;
    lpd_nxt      = lpd_r;
    press_nxt    = press_r;
    ev           = SW_NONE;
    if ((raw != stable_r) &&
        (since_change >= TIME_WIDTH'(debounce_len))) begin
      stable_nxt = raw;
      if (raw) begin
        press_nxt = now;
        lpd_nxt   = 1'b0;
        ev        = SW_PRESSED;
      end else begin
        ev = SW_RELEASED;
      end
    end else if (stable_r && !lpd_r &&
                 (since_press >= TIME_WIDTH'(hold_len))) begin
      lpd_nxt = 1'b1;
      ev      = SW_LONG;
    end
    result.ev        = ev;
    result.long_seen = lpd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      lpd_r    <= 1'b0;
      change_r <= '0;
      press_r  <= '0;
    end else if (en) begin
      raw_r    <= raw;
      stable_r <= stable_nxt;
      lpd_r    <= lpd_nxt;
      change_r <= change_nxt;
      press_r  <= press_nxt;
    end
  end

endmodule

`default_nettype wire
